### rtl/core/pva_pkg.sv
// ============================================================================
// pva_pkg
// Shared field widths, operation and mode codes, register indexes and the
// free queue control bundle for the voice allocator.
// ============================================================================
`default_nettype none

package pva_pkg;

  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int VNUM_W     = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OLDEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOWER  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEAL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT = 2'd1;

  localparam int VC_RESET = 16;

  typedef struct packed {
    logic rebuild;
    logic rd;
    logic pop;
    logic push;
  } fq_ctl_t;

endpackage

`default_nettype wire

### rtl/core/pva_ram.sv
// ============================================================================
// pva_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/pva_free_q.sv
// ============================================================================
// pva_free_q
// Circular queue of free voices. Entries not written since the last rebuild
// read as their own address, which gives the in-order voice list at once.
// ============================================================================
`default_nettype none

module pva_free_q #(
  parameter int NUM_VOICES  = 16,
  parameter int RESET_COUNT = 16
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire pva_pkg::fq_ctl_t                                 ctl,
  input  wire logic [$clog2(NUM_VOICES+1)-1:0]                  rebuild_count,
  input  wire logic [(NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1)-1:0] push_voice,
  output logic      [(NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1)-1:0] head_voice,
  output logic      [$clog2(NUM_VOICES+1)-1:0]                  count
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam int SUMW = CW + 1;

  logic [VW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [NUM_VOICES-1:0] written_r, written_nxt;
  logic                  was_written_r;
  logic [VW-1:0]         rd_addr_r;
  logic [SUMW-1:0]       tail_sum;
  logic [VW-1:0]         tail;
  logic [VW-1:0]         ram_rdata;

  always_comb begin
    tail_sum = SUMW'(head_r) + SUMW'(count_r);
    if (tail_sum >= SUMW'(NUM_VOICES)) begin
      tail = VW'(tail_sum - SUMW'(NUM_VOICES));
    end else begin
      tail = VW'(tail_sum);
    end
  end

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    written_nxt = written_r;
    if (ctl.rebuild) begin
      head_nxt    = '0;
      count_nxt   = rebuild_count;
      written_nxt = '0;
    end else if (ctl.pop) begin
      if (head_r == VW'(NUM_VOICES - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + VW'(1);
      end
      count_nxt = count_r - CW'(1);
    end else if (ctl.push) begin
      written_nxt[tail] = 1'b1;
      count_nxt         = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= CW'(RESET_COUNT);
      written_r <= '0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      written_r <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      was_written_r <= written_r[head_r];
      rd_addr_r     <= head_r;
    end
  end

  pva_ram #(
    .WIDTH (VW),
    .DEPTH (NUM_VOICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.push),
    .wr_addr (tail),
    .wr_data (push_voice),
    .rd_en   (ctl.rd),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );

  assign head_voice = was_written_r ? ram_rdata : rd_addr_r;
  assign count      = count_r;

endmodule

`default_nettype wire

### rtl/core/polyphonic_voice_allocator_core.sv
// ============================================================================
// polyphonic_voice_allocator_core
// Assigns voices to note-on events and releases them on note-off, with
// optional stealing of a sounding voice when no voice is free.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_stall  | operation, note, velocity
//  out_    | output    | out_valid/out_stall| voice_number, gate, voice_note,
//          |           |                    | voice_velocity
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Note-on with a free voice: free queue read, commit, emit.
//  Steal or note-off: accept, scan the sounding entries, shift the entries
//  behind the chosen one, commit, emit; no result when no entry is chosen.
//  Scan and shift read one entry at a time over the single RAM read port.
//  Reset is synchronous; no clearing pass, the free queue is rebuilt at once.
//  in_stall is high while a transaction is in work; one result waits in the
//  output register while the next transaction is taken.
// ============================================================================
`default_nettype none

module polyphonic_voice_allocator_core #(
  parameter int NUM_VOICES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_operation,
  input  wire logic [pva_pkg::NOTE_W-1:0]        in_note,
  input  wire logic [pva_pkg::VEL_W-1:0]         in_velocity,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [pva_pkg::VNUM_W-1:0]        out_voice_number,
  output logic                                   out_gate,
  output logic      [pva_pkg::NOTE_W-1:0]        out_voice_note,
  output logic      [pva_pkg::VEL_W-1:0]         out_voice_velocity,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pva_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pva_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int VW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW   = $clog2(NUM_VOICES + 1);
  localparam int NW   = pva_pkg::NOTE_W;
  localparam int SW   = NW + VW;
  localparam int VNW  = pva_pkg::VNUM_W;
  localparam int CLW  = 7;
  localparam int VC_RST = (pva_pkg::VC_RESET > NUM_VOICES) ? NUM_VOICES : pva_pkg::VC_RESET;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FREE_RD = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_WALK    = 3'd3;
  localparam logic [2:0] ST_FINISH  = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               scount_r, scount_nxt;
  logic [pva_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        pend_r, pend_nxt;
  logic                        wpend_r, wpend_nxt;
  logic                        found_r, found_nxt;

  logic                        op_r, op_nxt;
  logic [NW-1:0]               note_r, note_nxt;
  logic [pva_pkg::VEL_W-1:0]   vel_r, vel_nxt;
  logic [NW-1:0]               low_r, low_nxt;
  logic [CW-1:0]               scan_idx_r, scan_idx_nxt;
  logic [VW-1:0]               pend_pos_r, pend_pos_nxt;
  logic [VW-1:0]               hit_pos_r, hit_pos_nxt;
  logic [VW-1:0]               hit_voice_r, hit_voice_nxt;
  logic [CW-1:0]               walk_idx_r, walk_idx_nxt;
  logic [VW-1:0]               wpos_r, wpos_nxt;
  logic [VW-1:0]               out_voice_r, out_voice_nxt;
  logic                        out_gate_r, out_gate_nxt;
  logic [NW-1:0]               out_note_r, out_note_nxt;
  logic [pva_pkg::VEL_W-1:0]   out_vel_r, out_vel_nxt;

  pva_pkg::fq_ctl_t            fq_ctl;
  logic [CW-1:0]               fq_count;
  logic [VW-1:0]               fq_head_voice;
  logic [CLW-1:0]              cfg_wide;
  logic [CW-1:0]               vc_clamped;

  logic                        snd_we;
  logic [VW-1:0]               snd_waddr;
  logic [SW-1:0]               snd_wdata;
  logic                        snd_re;
  logic [VW-1:0]               snd_raddr;
  logic [SW-1:0]               snd_rdata;

  logic [NW-1:0]               entry_note;
  logic [VW-1:0]               entry_voice;
  logic [NW-1:0]               cmp_key;
  logic                        cmp_eq;
  logic                        cmp_lt;
  logic                        match;
  logic                        first_hit;
  logic                        hit_now;
  logic                        scan_more;
  logic                        walk_more;
  logic [VW-1:0]               walk_from;

  always_comb begin
    cfg_wide = CLW'(cfg_data);
    if (cfg_wide == '0) begin
      vc_clamped = CW'(1);
    end else if (cfg_wide > CLW'(NUM_VOICES)) begin
      vc_clamped = CW'(NUM_VOICES);
    end else begin
      vc_clamped = CW'(cfg_wide);
    end
  end

  assign entry_note  = snd_rdata[SW-1:VW];
  assign entry_voice = snd_rdata[VW-1:0];
  assign cmp_key     = (op_r == pva_pkg::OP_NOTE_OFF) ? note_r : low_r;
  assign cmp_eq      = (entry_note == cmp_key);
  assign cmp_lt      = (entry_note < cmp_key);
  assign first_hit   = (op_r == pva_pkg::OP_NOTE_OFF) || (mode_r == pva_pkg::MODE_OLDEST);
  assign scan_more   = (scan_idx_r < scount_r);
  assign walk_more   = (walk_idx_r < scount_r);
  assign hit_now     = pend_r && match;
  assign walk_from   = hit_now ? pend_pos_r : hit_pos_r;

  always_comb begin
    if (op_r == pva_pkg::OP_NOTE_OFF) begin
      match = cmp_eq;
    end else if (mode_r == pva_pkg::MODE_OLDEST) begin
      match = 1'b1;
    end else begin
      match = cmp_lt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scount_nxt    = scount_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && out_stall;
    pend_nxt      = pend_r;
    wpend_nxt     = wpend_r;
    found_nxt     = found_r;
    op_nxt        = op_r;
    note_nxt      = note_r;
    vel_nxt       = vel_r;
    low_nxt       = low_r;
    scan_idx_nxt  = scan_idx_r;
    pend_pos_nxt  = pend_pos_r;
    hit_pos_nxt   = hit_pos_r;
    hit_voice_nxt = hit_voice_r;
    walk_idx_nxt  = walk_idx_r;
    wpos_nxt      = wpos_r;
    out_voice_nxt = out_voice_r;
    out_gate_nxt  = out_gate_r;
    out_note_nxt  = out_note_r;
    out_vel_nxt   = out_vel_r;
    fq_ctl        = '0;
    snd_we        = 1'b0;
    snd_waddr     = scount_r[VW-1:0];
    snd_wdata     = {note_r, hit_voice_r};
    snd_re        = 1'b0;
    snd_raddr     = scan_idx_r[VW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == pva_pkg::REG_STEAL_MODE) begin
            mode_nxt = cfg_data[pva_pkg::MODE_W-1:0];
          end else if (cfg_index == pva_pkg::REG_VOICE_COUNT) begin
            fq_ctl.rebuild = 1'b1;
            scount_nxt     = '0;
          end
        end
        if (in_valid) begin
          op_nxt       = in_operation;
          note_nxt     = in_note;
          vel_nxt      = in_velocity;
          low_nxt      = in_note;
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          found_nxt    = 1'b0;
          if (in_operation == pva_pkg::OP_NOTE_ON && fq_count != '0) begin
            fq_ctl.rd = 1'b1;
            state_nxt = ST_FREE_RD;
          end else if (scount_r != '0 && (in_operation == pva_pkg::OP_NOTE_OFF ||
                       mode_r == pva_pkg::MODE_OLDEST || mode_r == pva_pkg::MODE_LOWER)) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_FREE_RD: begin
        hit_voice_nxt = fq_head_voice;
        fq_ctl.pop    = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_SCAN: begin
        pend_nxt = scan_more;
        if (scan_more) begin
          snd_re       = 1'b1;
          snd_raddr    = scan_idx_r[VW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
          pend_pos_nxt = scan_idx_r[VW-1:0];
        end
        if (hit_now) begin
          found_nxt     = 1'b1;
          hit_pos_nxt   = pend_pos_r;
          hit_voice_nxt = entry_voice;
          low_nxt       = entry_note;
        end
        if ((hit_now && first_hit) || (!scan_more && !pend_r && found_r)) begin
          walk_idx_nxt = CW'(walk_from) + CW'(1);
          wpend_nxt    = 1'b0;
          state_nxt    = ST_WALK;
        end else if (!scan_more && !pend_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        wpend_nxt = walk_more;
        if (walk_more) begin
          snd_re       = 1'b1;
          snd_raddr    = walk_idx_r[VW-1:0];
          walk_idx_nxt = walk_idx_r + CW'(1);
          wpos_nxt     = VW'(walk_idx_r - CW'(1));
        end
        if (wpend_r) begin
          snd_we    = 1'b1;
          snd_waddr = wpos_r;
          snd_wdata = snd_rdata;
        end
        if (!walk_more && !wpend_r) begin
          scount_nxt = scount_r - CW'(1);
          state_nxt  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (op_r == pva_pkg::OP_NOTE_ON) begin
          snd_we     = 1'b1;
          scount_nxt = scount_r + CW'(1);
        end else begin
          fq_ctl.push = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_voice_nxt = hit_voice_r;
          out_gate_nxt  = (op_r == pva_pkg::OP_NOTE_ON);
          out_note_nxt  = note_r;
          out_vel_nxt   = (op_r == pva_pkg::OP_NOTE_ON) ? vel_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scount_r    <= '0;
      mode_r      <= pva_pkg::MODE_NONE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      wpend_r     <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scount_r    <= scount_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      wpend_r     <= wpend_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    note_r      <= note_nxt;
    vel_r       <= vel_nxt;
    low_r       <= low_nxt;
    scan_idx_r  <= scan_idx_nxt;
    pend_pos_r  <= pend_pos_nxt;
    hit_pos_r   <= hit_pos_nxt;
    hit_voice_r <= hit_voice_nxt;
    walk_idx_r  <= walk_idx_nxt;
    wpos_r      <= wpos_nxt;
    out_voice_r <= out_voice_nxt;
    out_gate_r  <= out_gate_nxt;
    out_note_r  <= out_note_nxt;
    out_vel_r   <= out_vel_nxt;
  end

  pva_free_q #(
    .NUM_VOICES  (NUM_VOICES),
    .RESET_COUNT (VC_RST)
  ) u_free_q (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (fq_ctl),
    .rebuild_count (vc_clamped),
    .push_voice    (hit_voice_r),
    .head_voice    (fq_head_voice),
    .count         (fq_count)
  );

  pva_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_VOICES)
  ) u_sounding_ram (
    .clk     (clk),
    .wr_en   (snd_we),
    .wr_addr (snd_waddr),
    .wr_data (snd_wdata),
    .rd_en   (snd_re),
    .rd_addr (snd_raddr),
    .rd_data (snd_rdata)
  );

  assign in_stall           = (state_r != ST_IDLE);
  assign cfg_ready          = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_voice_number   = VNW'(out_voice_r);
  assign out_gate           = out_gate_r;
  assign out_voice_note     = out_note_r;
  assign out_voice_velocity = out_vel_r;

  a_voice_total: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW+1)'(scount_r) + (CW+1)'(fq_count)) <= (CW+1)'(NUM_VOICES))
    else $error("free and sounding voices exceed the voice pool");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scount_r != '0)
    else $error("scan started on an empty sounding queue");

  a_walk_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> found_r)
    else $error("queue shift without a chosen voice");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && op_r == pva_pkg::OP_NOTE_ON) |-> scount_r < CW'(NUM_VOICES))
    else $error("sounding queue full at append");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded when output register was free");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Voice allocator core testbench
// Drives note-on and note-off transactions with random gaps and output stalls,
// walks a short directed table, then random phases under varied steal modes
// and voice counts. Every result is checked against a behavioral allocator.
// ============================================================================
module tb;

  localparam int NV         = 16;
  localparam int SETTLE_CYC = 2 * NV + 24;
  localparam int N_ITEMS    = 1950;

  localparam int NOTE_W     = pva_pkg::NOTE_W;
  localparam int VEL_W      = pva_pkg::VEL_W;
  localparam int VNUM_W     = pva_pkg::VNUM_W;
  localparam int MODE_W     = pva_pkg::MODE_W;
  localparam int CFG_IDX_W  = pva_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pva_pkg::CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {ROW_EVT, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_DROP, EXP_VOICE} exp_kind_t;

  typedef struct packed {
    logic [VNUM_W-1:0] voice;
    logic              gate;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } voice_evt_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    logic [NOTE_W-1:0]     note;
    logic [VEL_W-1:0]      vel;
    exp_kind_t             ek;
    logic [VNUM_W-1:0]     voice;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = pva_pkg::OP_NOTE_ON;
  logic [NOTE_W-1:0]     in_note = '0;
  logic [VEL_W-1:0]      in_velocity = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VNUM_W-1:0]     out_voice_number;
  logic                  out_gate;
  logic [NOTE_W-1:0]     out_voice_note;
  logic [VEL_W-1:0]      out_voice_velocity;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  polyphonic_voice_allocator_core #(.NUM_VOICES(NV)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_note            (in_note),
    .in_velocity        (in_velocity),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_voice_number   (out_voice_number),
    .out_gate           (out_gate),
    .out_voice_note     (out_voice_note),
    .out_voice_velocity (out_voice_velocity),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // allocator state
  logic [VNUM_W-1:0] free_q[$];
  logic [VNUM_W-1:0] sound_q[$];
  logic [NOTE_W-1:0] held_note[NV];
  logic [MODE_W-1:0] mode_r;
  int                vcount_r;

  voice_evt_t voice_q[$];
  dir_row_t   dir_tab[$];
  int         errors = 0;
  int         n_events = 0;
  int         n_results = 0;
  int         n_settings = 0;
  int         rx_hold = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;

  function automatic void rebuild_voices();
    free_q.delete();
    sound_q.delete();
    for (int i = 0; i < NV; i++) held_note[i] = '0;
    for (int i = 0; i < vcount_r; i++) free_q = {free_q, VNUM_W'(i)};
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == pva_pkg::REG_STEAL_MODE) begin
      mode_r = data[MODE_W-1:0];
    end else if (idx == pva_pkg::REG_VOICE_COUNT) begin
      vcount_r = (data == 0) ? 1 : (data > NV) ? NV : int'(data);
      rebuild_voices();
    end
  endfunction

  function automatic void unlink_voice(logic [VNUM_W-1:0] v);
    for (int i = 0; i < sound_q.size(); i++) begin
      if (sound_q[i] == v) begin
        sound_q.delete(i);
        break;
      end
    end
    for (int i = 0; i < free_q.size(); i++) begin
      if (free_q[i] == v) begin
        free_q.delete(i);
        break;
      end
    end
  endfunction

  function automatic bit allocate_voice(logic op, logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vel,
                                        output voice_evt_t r);
    logic [VNUM_W-1:0] v;
    logic [NOTE_W-1:0] lowest;
    bit                hit;
    v = '0;
    lowest = nt;
    hit = 1'b0;
    r = '0;
    if (op == pva_pkg::OP_NOTE_ON) begin
      if (free_q.size() > 0) begin
        v = free_q[0];
        hit = 1'b1;
      end else if (mode_r == pva_pkg::MODE_OLDEST) begin
        if (sound_q.size() > 0) begin
          v = sound_q[0];
          hit = 1'b1;
        end
      end else if (mode_r == pva_pkg::MODE_LOWER) begin
        for (int i = 0; i < sound_q.size(); i++) begin
          if (held_note[sound_q[i]] < lowest) begin
            lowest = held_note[sound_q[i]];
            v = sound_q[i];
            hit = 1'b1;
          end
        end
      end
      if (!hit) return 1'b0;
      held_note[v] = nt;
      unlink_voice(v);
      sound_q = {sound_q, v};
      r.gate = 1'b1;
      r.vel = vel;
    end else begin
      for (int i = 0; i < sound_q.size(); i++) begin
        if (held_note[sound_q[i]] == nt) begin
          v = sound_q[i];
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return 1'b0;
      unlink_voice(v);
      free_q = {free_q, v};
    end
    r.voice = v;
    r.note = nt;
    return 1'b1;
  endfunction

  function automatic dir_row_t ev_row(logic op, int nt, int vel, exp_kind_t ek, int v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_EVT;
    r.op = op;
    r.note = NOTE_W'(nt);
    r.vel = VEL_W'(vel);
    r.ek = ek;
    r.voice = VNUM_W'(v);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  task automatic play_event(logic op, logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vel,
                            exp_kind_t ek, logic [VNUM_W-1:0] tv);
    voice_evt_t pred;
    voice_evt_t typed;
    bit         has;
    int         g;
    in_valid <= 1'b1;
    in_operation <= op;
    in_note <= nt;
    in_velocity <= vel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = allocate_voice(op, nt, vel, pred);
    n_events++;
    if (ek == EXP_PREDICT) begin
      if (has) voice_q = {voice_q, pred};
    end else if (ek == EXP_DROP) begin
      if (has) begin
        $display("%0t: note %0d expected no result, allocator gives voice %0d",
                 $time, nt, pred.voice);
        errors++;
      end
    end else begin
      typed.voice = tv;
      typed.gate = (op == pva_pkg::OP_NOTE_ON);
      typed.note = nt;
      typed.vel = (op == pva_pkg::OP_NOTE_ON) ? vel : '0;
      if (!has || pred != typed) begin
        $display("%0t: note %0d expected voice %0d, allocator gives %0d (hit %0d)",
                 $time, nt, tv, pred.voice, has);
        errors++;
      end
      voice_q = {voice_q, typed};
    end
    g = tx_quiet ? 0 : $urandom_range(0, 13);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (voice_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (voice_q.size() > 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    n_settings++;
  endtask

  // result side: check each transaction, then draw the next stall
  always @(posedge clk) begin
    voice_evt_t got;
    voice_evt_t want;
    got.voice = out_voice_number;
    got.gate = out_gate;
    got.note = out_voice_note;
    got.vel = out_voice_velocity;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (voice_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got voice %0d gate %0d note %0d vel %0d",
                 $time, got.voice, got.gate, got.note, got.vel);
        errors++;
      end else begin
        want = voice_q.pop_front();
        if (got.voice !== want.voice) begin
          $display("%0t: voice_number expected %0d got %0d", $time, want.voice, got.voice);
          errors++;
        end
        if (got.gate !== want.gate) begin
          $display("%0t: gate expected %0d got %0d", $time, want.gate, got.gate);
          errors++;
        end
        if (got.note !== want.note) begin
          $display("%0t: voice_note expected %0d got %0d", $time, want.note, got.note);
          errors++;
        end
        if (got.vel !== want.vel) begin
          $display("%0t: voice_velocity expected %0d got %0d", $time, want.vel, got.vel);
          errors++;
        end
      end
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 13);
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
    end
    out_stall <= (rx_hold > 0);
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, voice_q.size());
    $display("polyphonic_voice_allocator_core test failed");
    $finish;
  end

  initial begin
    logic [NOTE_W-1:0] pool[6];
    logic              op;
    logic [NOTE_W-1:0] nt;
    int                phase;
    int                len;
    int                hold_at;
    int                on_pct;
    int                pick;
    logic [CFG_DATA_W-1:0] vc_data;
    bit                prev_cfg;

    mode_r = pva_pkg::MODE_NONE;
    vcount_r = pva_pkg::VC_RESET;
    rebuild_voices();

    add_row(ev_row(pva_pkg::OP_NOTE_ON,    0,   0, EXP_VOICE,   0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,  127, 127, EXP_VOICE,   1));
    add_row(ev_row(pva_pkg::OP_NOTE_OFF, 127, 127, EXP_VOICE,   1));
    add_row(ev_row(pva_pkg::OP_NOTE_OFF,   5,  64, EXP_DROP,    0));
    add_row(ev_row(pva_pkg::OP_NOTE_OFF,   0,   0, EXP_VOICE,   0));
    add_row(cfg_row(pva_pkg::REG_VOICE_COUNT, 5'd2));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   60, 100, EXP_VOICE,   0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   64,  90, EXP_VOICE,   1));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   70,  80, EXP_DROP,    0));
    add_row(cfg_row(pva_pkg::REG_STEAL_MODE, 5'd3));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   72,  50, EXP_DROP,    0));
    add_row(cfg_row(pva_pkg::REG_STEAL_MODE, {3'b0, pva_pkg::MODE_OLDEST}));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   72,  50, EXP_PREDICT, 0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   10,   1, EXP_PREDICT, 0));
    add_row(cfg_row(pva_pkg::REG_STEAL_MODE, {3'b0, pva_pkg::MODE_LOWER}));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,    5,   5, EXP_DROP,    0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   73,  20, EXP_PREDICT, 0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   72,  33, EXP_DROP,    0));
    add_row(ev_row(pva_pkg::OP_NOTE_OFF,  73,   0, EXP_PREDICT, 0));
    add_row(cfg_row(REG_SPARE_A, 5'd31));
    add_row(cfg_row(REG_SPARE_B, 5'd0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   40,  64, EXP_PREDICT, 0));
    add_row(cfg_row(pva_pkg::REG_VOICE_COUNT, 5'd0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,  127, 127, EXP_VOICE,   0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,  127,   1, EXP_DROP,    0));
    add_row(ev_row(pva_pkg::OP_NOTE_OFF, 127,  99, EXP_VOICE,   0));
    add_row(cfg_row(pva_pkg::REG_VOICE_COUNT, 5'd2));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   30,  10, EXP_VOICE,   0));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   30,  11, EXP_VOICE,   1));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,   50,  12, EXP_PREDICT, 0));
    add_row(ev_row(pva_pkg::OP_NOTE_OFF,  30,   0, EXP_PREDICT, 0));
    add_row(cfg_row(pva_pkg::REG_VOICE_COUNT, 5'd31));
    add_row(ev_row(pva_pkg::OP_NOTE_ON,    1,   2, EXP_VOICE,   0));
    add_row(cfg_row(pva_pkg::REG_STEAL_MODE, 5'd16));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    prev_cfg = 1'b0;
    for (int r = 0; r < dir_tab.size(); r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        if (!prev_cfg) settle_idle();
        write_reg(dir_tab[r].idx, dir_tab[r].data);
        if (r + 1 == dir_tab.size() || dir_tab[r + 1].kind != ROW_CFG) cfg_valid <= 1'b0;
        prev_cfg = 1'b1;
      end else begin
        play_event(dir_tab[r].op, dir_tab[r].note, dir_tab[r].vel,
                   dir_tab[r].ek, dir_tab[r].voice);
        prev_cfg = 1'b0;
      end
    end

    phase = 0;
    while (n_events < N_ITEMS) begin
      settle_idle();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (phase == 0) vc_data = 5'd1;
      else if (phase == 1) vc_data = 5'd16;
      else if (pick < 6) vc_data = 5'($urandom_range(1, 5));
      else if (pick < 8) vc_data = 5'($urandom_range(6, 16));
      else if (pick == 8) vc_data = 5'd0;
      else vc_data = 5'($urandom_range(17, 31));
      if ($urandom_range(0, 1)) begin
        write_reg(pva_pkg::REG_VOICE_COUNT, vc_data);
        write_reg(pva_pkg::REG_STEAL_MODE, {3'($urandom_range(0, 7)), 2'(phase)});
      end else begin
        write_reg(pva_pkg::REG_STEAL_MODE, {3'($urandom_range(0, 7)), 2'(phase)});
        write_reg(pva_pkg::REG_VOICE_COUNT, vc_data);
      end
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 5'($urandom_range(0, 31)));
      cfg_valid <= 1'b0;

      foreach (pool[i]) pool[i] = 7'($urandom_range(0, 127));
      len = $urandom_range(40, 120);
      hold_at = $urandom_range(0, len - 1);
      on_pct = $urandom_range(45, 80);
      for (int k = 0; k < len; k++) begin
        op = ($urandom_range(0, 99) < on_pct) ? pva_pkg::OP_NOTE_ON : pva_pkg::OP_NOTE_OFF;
        pick = $urandom_range(0, 9);
        if (op == pva_pkg::OP_NOTE_OFF && pick < 7 && sound_q.size() > 0)
          nt = held_note[sound_q[$urandom_range(0, sound_q.size() - 1)]];
        else if (pick < 8)
          nt = pool[$urandom_range(0, 5)];
        else
          nt = 7'($urandom_range(0, 127));
        play_event(op, nt, 7'($urandom_range(0, 127)), EXP_PREDICT, '0);
        if (k == hold_at) hold_for_results();
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (voice_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Ran %0d note transactions over %0d register writes and %0d random phases;",
             n_events, n_settings, phase);
    $display("%0d voice results checked, %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("polyphonic_voice_allocator_core test passed");
    end else begin
      $display("polyphonic_voice_allocator_core test failed");
    end
    $finish;
  end

endmodule
